// ===== rtl/ds_twr_range_median_filter_core_assert.svh =====
// Assertion macros for the ranging median filter checker.
// Included by the checker file; holds nothing but macro definitions.
`ifndef DS_TWR_RANGE_MEDIAN_FILTER_CORE_ASSERT_SVH
`define DS_TWR_RANGE_MEDIAN_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DSTWR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ds_twr checker: property failed");

// Next-cycle implication, disabled while reset is low.
`define DSTWR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ds_twr checker: property failed");

`endif

// ===== rtl/dstwr_pkg.sv =====
// Package for the double-sided two-way ranging median filter.
// Holds the request and result structs and the fixed constants; no dependencies.
`default_nettype none

package dstwr_pkg;

    typedef struct packed {
        logic [2:0]  anchor_slot;
        logic [31:0] remote_poll_tx;
        logic [31:0] remote_resp_rx;
        logic [31:0] remote_final_tx;
        logic [31:0] local_poll_rx;
        logic [31:0] local_resp_tx;
        logic [31:0] local_final_rx;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic signed [31:0] flight_ticks;
        logic signed [23:0] raw_cm_q4;
        logic [18:0]        median_cm;
        logic [7:0]         median_metres;
        logic [6:0]         median_cm_rest;
    } t_out_item;

    localparam logic [15:0] CM_PER_TICK_RESET = 16'd30739;
    localparam logic [23:0] RAW_POS_MAX       = 24'h7F_FFFF;
    localparam logic [23:0] RAW_NEG_MAX       = 24'h80_0000;
    localparam logic [47:0] ROUND_Q12         = 48'd2048;
    // floor(x / 100) is (x * RECIP_100) >> 22 or one less for x below 2^19.
    localparam logic [15:0] RECIP_100         = 16'd41943;
    localparam logic [6:0]  CM_PER_M          = 7'd100;

endpackage

`default_nettype wire

// ===== rtl/ds_twr_range_median_filter_core.sv =====
// Double-sided two-way ranging with a per-anchor median of the last distances.
// Depends on dstwr_pkg for the request and result structs and constants.
`default_nettype none

// Each request is one finished ranging exchange for one anchor slot. The block
// forms the four intervals, takes the time of flight through one shared 32x32
// multiplier and a 64-step restoring divider, scales it to cm Q4, stores it in
// that slot's ring and reports the rounded median of the ring. A zero denominator
// skips the divider and the scaling. A slot number at or above NUM_ANCHORS is
// first folded below it, and a finished result waits until the output register
// is free. The 64 iterations of the divider take most of the time from one
// accepted request to the earliest next one. o_in_stall is high for the whole of
// that time. The result sits in an output register, so the next request is taken
// while the previous result still waits.
// The ring memory needs no clearing pass: per-slot valid bits in flip-flops mark
// which slots have been written since reset.
module ds_twr_range_median_filter_core #(
    parameter int NUM_ANCHORS = 8,
    parameter int WINDOW      = 5
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  dstwr_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output dstwr_pkg::t_out_item  o_out_data,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [15:0]            i_cfg_data
);

    localparam int SW    = (NUM_ANCHORS > 1) ? $clog2(NUM_ANCHORS) : 1;
    localparam int PW    = $clog2(WINDOW);
    localparam int KW    = $clog2(WINDOW + 1);
    localparam int DEPTH = NUM_ANCHORS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int MID   = WINDOW / 2;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT, S_MUL1, S_MUL2, S_DIFF, S_DIV, S_QSAT, S_SCALE,
        S_SAT, S_WRITE, S_READ, S_MED, S_DIVC1, S_DIVC2, S_DONE
    } t_state;

    typedef struct packed {
        logic          full;
        logic [PW-1:0] pos;
    } t_meta;

    t_state r_state;

    logic [15:0] r_cm;
    logic [2:0]  r_slot3;
    logic [SW-1:0] r_slot;
    logic [AW-1:0] r_base;
    logic [31:0] r_ra, r_rb, r_da, r_db;
    logic [33:0] r_den;
    logic [63:0] r_p1, r_p2, r_prod;
    logic [63:0] r_num;
    logic [33:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [31:0] r_qsat;
    logic        r_status;
    logic signed [31:0] r_flight;
    logic signed [23:0] r_raw;
    logic [NUM_ANCHORS-1:0] r_row_vld;
    logic        r_rowok;
    logic        r_full;
    logic [PW-1:0] r_pos;
    logic [KW-1:0] r_k, r_pk;
    logic        r_pend;
    logic signed [23:0] r_srt [WINDOW];
    logic [18:0] r_med;
    logic [12:0] r_qa;
    logic [7:0]  r_metres;
    logic [6:0]  r_rest;
    logic        r_out_valid;
    dstwr_pkg::t_out_item r_out;

    logic signed [23:0] r_ring [DEPTH];
    logic signed [23:0] r_rdq;
    t_meta       r_meta_mem [NUM_ANCHORS];
    t_meta       r_meta_q;

    // Shared multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    always_comb begin
        unique case (r_state)
            S_MUL1: begin
                mul_a = r_ra;
                mul_b = r_rb;
            end
            S_MUL2: begin
                mul_a = r_da;
                mul_b = r_db;
            end
            default: begin
                mul_a = r_qsat;
                mul_b = {16'd0, r_cm};
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Divider step.
    logic [34:0] div_sh;
    logic        div_ge;
    logic [33:0] div_rem;

    always_comb begin
        div_sh  = {r_rem, r_num[63]};
        div_ge  = div_sh >= {1'b0, r_den};
        div_rem = div_ge ? 34'(div_sh - {1'b0, r_den}) : div_sh[33:0];
    end

    // Rounding and saturation of the scaled distance.
    logic [47:0] sat_rnd;
    logic [35:0] sat_r;
    logic [23:0] sat_mag;

    always_comb begin
        sat_rnd = r_prod[47:0] + dstwr_pkg::ROUND_Q12;
        sat_r   = sat_rnd[47:12];
        if (r_neg) begin
            sat_mag = (sat_r > 36'(dstwr_pkg::RAW_NEG_MAX)) ? dstwr_pkg::RAW_NEG_MAX
                                                            : sat_r[23:0];
        end else begin
            sat_mag = (sat_r > 36'(dstwr_pkg::RAW_POS_MAX)) ? dstwr_pkg::RAW_POS_MAX
                                                            : sat_r[23:0];
        end
    end

    // Ring position bookkeeping for the write step.
    logic          pos_full_cur;
    logic [PW-1:0] pos_cur;
    logic          pos_wrap;
    logic [PW-1:0] pos_next;
    logic          ring_we;

    always_comb begin
        pos_full_cur = r_row_vld[r_slot] ? r_meta_q.full : 1'b0;
        pos_cur      = r_row_vld[r_slot] ? r_meta_q.pos : '0;
        pos_wrap     = pos_cur == PW'(WINDOW - 1);
        pos_next     = pos_wrap ? '0 : PW'(pos_cur + 1'b1);
        ring_we      = (r_state == S_WRITE) && !r_status;
    end

    // Read address walks the slot's entries; entries never written read as zero.
    logic [AW-1:0] rd_addr;
    logic          ins_ok;
    logic signed [23:0] ins_v;
    logic [WINDOW-1:0]  ins_gt;
    logic signed [23:0] n_srt [WINDOW];

    always_comb begin
        rd_addr = r_base + ((r_k < KW'(WINDOW)) ? AW'(r_k) : AW'(0));
        ins_ok  = r_rowok && (r_full || (r_pk < KW'(r_pos)));
        ins_v   = ins_ok ? r_rdq : 24'sd0;
        for (int i = 0; i < WINDOW; i++) begin
            ins_gt[i] = r_srt[i] > ins_v;
        end
        // Each lane keeps, takes the new value, or takes its lower neighbor.
        for (int i = 0; i < WINDOW; i++) begin
            if (!ins_gt[i]) begin
                n_srt[i] = r_srt[i];
            end else if (i == 0) begin
                n_srt[i] = ins_v;
            end else if (!ins_gt[i-1]) begin
                n_srt[i] = ins_v;
            end else begin
                n_srt[i] = r_srt[i-1];
            end
        end
    end

    // Median formed in cm with five fraction bits, then rounded half up to whole cm.
    logic signed [25:0] med_sum;
    logic [18:0]        med_cm;

    always_comb begin
        if ((WINDOW % 2) == 1) begin
            med_sum = (26'(r_srt[MID]) <<< 1) + 26'sd16;
        end else begin
            med_sum = 26'(r_srt[MID-1]) + 26'(r_srt[MID]) + 26'sd16;
        end
        if (med_sum[25]) begin
            med_cm = '0;
        end else if (med_sum[24]) begin
            med_cm = '1;
        end else begin
            med_cm = med_sum[23:5];
        end
    end

    // Metres and remainder by reciprocal multiply with one correction.
    logic [34:0] dc_prod;
    logic [18:0] dc_diff;
    logic [12:0] dc_q;
    logic [7:0]  dc_rem;

    always_comb begin
        dc_prod = 35'(r_med) * 35'(dstwr_pkg::RECIP_100);
        dc_diff = r_med - 19'(20'(r_qa) * 20'(dstwr_pkg::CM_PER_M));
        if (dc_diff[7:0] >= 8'(dstwr_pkg::CM_PER_M)) begin
            dc_q   = r_qa + 13'd1;
            dc_rem = dc_diff[7:0] - 8'(dstwr_pkg::CM_PER_M);
        end else begin
            dc_q   = r_qa;
            dc_rem = dc_diff[7:0];
        end
    end

    // Ring and per-slot position memories.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_base + AW'(pos_cur)] <= r_raw;
        end
        r_rdq <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_meta_mem[r_slot] <= '{full: pos_full_cur || pos_wrap, pos: pos_next};
        end
        r_meta_q <= r_meta_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cm        <= dstwr_pkg::CM_PER_TICK_RESET;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cm <= i_cfg_data;
            end
            // A new result loaded in S_DONE sets the valid flag itself.
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_slot3 <= i_in_data.anchor_slot;
                        r_ra    <= i_in_data.remote_resp_rx - i_in_data.remote_poll_tx;
                        r_rb    <= i_in_data.local_final_rx - i_in_data.local_resp_tx;
                        r_da    <= i_in_data.remote_final_tx - i_in_data.remote_resp_rx;
                        r_db    <= i_in_data.local_resp_tx - i_in_data.local_poll_rx;
                        r_state <= S_SLOT;
                    end
                end
                S_SLOT: begin
                    if (32'(r_slot3) >= NUM_ANCHORS) begin
                        r_slot3 <= r_slot3 - 3'(NUM_ANCHORS);
                    end else begin
                        r_slot  <= SW'(r_slot3);
                        r_base  <= AW'(32'(r_slot3) * WINDOW);
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p1    <= mul_p;
                    r_den   <= 34'(r_ra) + 34'(r_rb) + 34'(r_da) + 34'(r_db);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= mul_p;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_neg <= r_p2 > r_p1;
                    r_num <= (r_p2 > r_p1) ? r_p2 - r_p1 : r_p1 - r_p2;
                    r_rem <= '0;
                    r_cnt <= '0;
                    if (r_den == '0) begin
                        r_status <= 1'b1;
                        r_flight <= '0;
                        r_raw    <= '0;
                        r_state  <= S_WRITE;
                    end else begin
                        r_status <= 1'b0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_rem;
                    r_num <= {r_num[62:0], div_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_QSAT;
                    end
                end
                S_QSAT: begin
                    // The saturated quotient may reach 2^31 only when the flight time is negative.
                    if (r_neg) begin
                        r_qsat <= (r_num > 64'h8000_0000) ? 32'h8000_0000 : r_num[31:0];
                    end else begin
                        r_qsat <= (r_num > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_num[31:0];
                    end
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod   <= mul_p;
                    r_flight <= r_neg ? 32'sd0 - $signed(r_qsat) : $signed(r_qsat);
                    r_state  <= S_SAT;
                end
                S_SAT: begin
                    r_raw   <= r_neg ? 24'sd0 - $signed(sat_mag) : $signed(sat_mag);
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (!r_status) begin
                        r_row_vld[r_slot] <= 1'b1;
                        r_rowok           <= 1'b1;
                        r_full            <= pos_full_cur || pos_wrap;
                        r_pos             <= pos_next;
                    end else begin
                        r_rowok <= r_row_vld[r_slot];
                        r_full  <= pos_full_cur;
                        r_pos   <= pos_cur;
                    end
                    for (int i = 0; i < WINDOW; i++) begin
                        r_srt[i] <= $signed(dstwr_pkg::RAW_POS_MAX);
                    end
                    r_k     <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_pend) begin
                        r_srt <= n_srt;
                    end
                    r_pend <= r_k < KW'(WINDOW);
                    r_pk   <= r_k;
                    if (r_k == KW'(WINDOW)) begin
                        r_state <= S_MED;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_MED: begin
                    r_med   <= med_cm;
                    r_state <= S_DIVC1;
                end
                S_DIVC1: begin
                    r_qa    <= dc_prod[34:22];
                    r_state <= S_DIVC2;
                end
                S_DIVC2: begin
                    r_metres <= (dc_q > 13'd255) ? 8'd255 : dc_q[7:0];
                    r_rest   <= dc_rem[6:0];
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{status: r_status, flight_ticks: r_flight,
                                   raw_cm_q4: r_raw, median_cm: r_med,
                                   median_metres: r_metres, median_cm_rest: r_rest};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/dstwr_checker.sv =====
// Port-level checker for the ranging median filter, bound to the core module.
// Depends on dstwr_pkg and the assertion macro header.
`default_nettype none
`include "ds_twr_range_median_filter_core_assert.svh"

module dstwr_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  i_in_stall,
    input wire                  i_out_valid,
    input wire                  i_out_stall,
    input dstwr_pkg::t_out_item i_out_data
);

    // A result held back by the receiver stays in place.
    `DSTWR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data))

    // A taken request keeps the block busy on the next cycle.
    `DSTWR_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)

    // A zero denominator reports no flight time and no distance.
    `DSTWR_ASSERT_NOW(a_zero_den, i_clk, i_rst_n, i_out_valid && i_out_data.status, (i_out_data.flight_ticks == 32'sd0) && (i_out_data.raw_cm_q4 == 24'sd0))

    // Metres and remainder put back together give the median unless metres saturated.
    `DSTWR_ASSERT_NOW(a_metres_split, i_clk, i_rst_n, i_out_valid, (i_out_data.median_cm_rest < 7'd100) && ((i_out_data.median_metres == 8'd255) || ((19'(i_out_data.median_metres) * 19'd100 + 19'(i_out_data.median_cm_rest)) == i_out_data.median_cm)))

endmodule

bind ds_twr_range_median_filter_core dstwr_checker u_dstwr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-way ranging median filter core.
// Depends on dstwr_pkg and the core; a small scoreboard predicts every result.
`default_nettype none

module testbench;

    localparam int SLOTS       = 8;
    localparam int DEPTH       = 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 120;

    // Predicts each result from the request stream and the current scale setting.
    class RangeScoreboard;
        logic signed [23:0]   dist_ring [SLOTS][DEPTH];
        int unsigned          write_pos [SLOTS];
        logic [15:0]          cm_per_tick;
        dstwr_pkg::t_out_item pending [$];
        int                   errors;
        int                   matched;
        int                   zero_den_seen;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                write_pos[s] = 0;
                for (int k = 0; k < DEPTH; k++) dist_ring[s][k] = '0;
            end
            cm_per_tick = dstwr_pkg::CM_PER_TICK_RESET;
            errors = 0;
            matched = 0;
            zero_den_seen = 0;
        endfunction

        function void note_request(dstwr_pkg::t_in_item req);
            logic [31:0]          ra, rb, da, db;
            longint unsigned      p1, p2, den, mag, q, r;
            bit                   neg;
            int unsigned          slot;
            int                   sorted [DEPTH];
            int                   tmp;
            longint               s;
            longint unsigned      med;
            dstwr_pkg::t_out_item res;
            slot = req.anchor_slot % SLOTS;
            ra = req.remote_resp_rx - req.remote_poll_tx;
            rb = req.local_final_rx - req.local_resp_tx;
            da = req.remote_final_tx - req.remote_resp_rx;
            db = req.local_resp_tx - req.local_poll_rx;
            p1 = longint'(ra) * longint'(rb);
            p2 = longint'(da) * longint'(db);
            den = longint'(ra) + longint'(rb) + longint'(da) + longint'(db);
            res = '0;
            if (den == 0) begin
                res.status = 1'b1;
                zero_den_seen++;
            end else begin
                neg = p2 > p1;
                mag = neg ? p2 - p1 : p1 - p2;
                q = mag / den;
                if (neg && q > 64'd2147483648) q = 64'd2147483648;
                if (!neg && q > 64'd2147483647) q = 64'd2147483647;
                r = (q * cm_per_tick + 64'd2048) >> 12;
                if (neg && r > 64'd8388608) r = 64'd8388608;
                if (!neg && r > 64'd8388607) r = 64'd8388607;
                res.flight_ticks = neg ? -q[31:0] : q[31:0];
                res.raw_cm_q4 = neg ? -r[23:0] : r[23:0];
                dist_ring[slot][write_pos[slot]] = res.raw_cm_q4;
                write_pos[slot] = (write_pos[slot] + 1) % DEPTH;
            end
            for (int k = 0; k < DEPTH; k++) sorted[k] = dist_ring[slot][k];
            for (int i = 1; i < DEPTH; i++)
                for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
                    tmp = sorted[j];
                    sorted[j] = sorted[j-1];
                    sorted[j-1] = tmp;
                end
            // The sum carries the median in cm with five fraction bits.
            if (DEPTH % 2) s = 2 * longint'(sorted[DEPTH/2]);
            else s = longint'(sorted[DEPTH/2-1]) + longint'(sorted[DEPTH/2]);
            s += 16;
            med = (s < 0) ? 0 : longint'(s) >> 5;
            if (med > 524287) med = 524287;
            res.median_cm = med[18:0];
            res.median_metres = (med / 100 > 255) ? 8'd255 : 8'(med / 100);
            res.median_cm_rest = 7'(med % 100);
            pending.push_back(res);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(dstwr_pkg::t_out_item got);
            dstwr_pkg::t_out_item want;
            if (pending.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.flight_ticks !== want.flight_ticks)
                report("flight_ticks", got.flight_ticks, want.flight_ticks);
            if (got.raw_cm_q4 !== want.raw_cm_q4)
                report("raw_cm_q4", got.raw_cm_q4, want.raw_cm_q4);
            if (got.median_cm !== want.median_cm)
                report("median_cm", got.median_cm, want.median_cm);
            if (got.median_metres !== want.median_metres)
                report("median_metres", got.median_metres, want.median_metres);
            if (got.median_cm_rest !== want.median_cm_rest)
                report("median_cm_rest", got.median_cm_rest, want.median_cm_rest);
            matched++;
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    dstwr_pkg::t_in_item  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    dstwr_pkg::t_out_item o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [15:0]          i_cfg_data = '0;

    RangeScoreboard ranges = new();
    bit          calm = 1'b0;
    int          cycles = 0;
    int          sent = 0;

    ds_twr_range_median_filter_core #(
        .NUM_ANCHORS (SLOTS),
        .WINDOW      (DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 14);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) ranges.note_request(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) ranges.check_result(o_out_data);
    end

    // Raises valid for one request, holding it through any stall.
    task send_request(dstwr_pkg::t_in_item req);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 14) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = req;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (ranges.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_scale(logic [15:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ranges.cm_per_tick = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // A consistent exchange: the replies take db and da, the flight takes tof.
    function automatic dstwr_pkg::t_in_item exchange(logic [2:0] slot, int tof,
                                                     logic [31:0] db, logic [31:0] da);
        dstwr_pkg::t_in_item t;
        t.anchor_slot     = slot;
        t.remote_poll_tx  = $urandom;
        t.local_poll_rx   = $urandom;
        t.local_resp_tx   = t.local_poll_rx + db;
        t.remote_resp_rx  = t.remote_poll_tx + db + 2 * tof;
        t.remote_final_tx = t.remote_resp_rx + da;
        t.local_final_rx  = t.local_resp_tx + da + 2 * tof;
        return t;
    endfunction

    function automatic dstwr_pkg::t_in_item noise();
        logic [223:0]        w;
        dstwr_pkg::t_in_item t;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        t = w[$bits(dstwr_pkg::t_in_item)-1:0];
        return t;
    endfunction

    function automatic dstwr_pkg::t_in_item random_request();
        int                  pick;
        int                  tof;
        dstwr_pkg::t_in_item t;
        pick = $urandom_range(99);
        if (pick < 70) tof = $urandom_range(30000);
        else if (pick < 80) tof = $urandom_range(1 << 24);
        else if (pick < 86) tof = -int'($urandom_range(20000));
        if (pick < 86)
            t = exchange(3'($urandom), tof, $urandom_range(1 << 24), $urandom_range(1 << 24));
        else if (pick < 89)
            t = exchange(3'($urandom), 0, 32'd0, 32'd0);
        else
            t = noise();
        return t;
    endfunction

    task random_phase(int count);
        for (int n = 0; n < count; n++) send_request(random_request());
    endtask

    initial begin
        dstwr_pkg::t_in_item t;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero denominator on an empty ring, then all-zero and all-one timestamps.
        send_request(exchange(3'd0, 0, 32'd0, 32'd0));
        send_request('0);
        t = '1;
        send_request(t);
        // Fill one ring with short hops and read the median back on a zero denominator.
        for (int k = 0; k < 6; k++) send_request(exchange(3'd7, 100 * k + 3, 32'd50000, 32'd60000));
        send_request(exchange(3'd7, 0, 32'd0, 32'd0));
        // Negative flight times push the median below zero.
        for (int k = 0; k < 3; k++) send_request(exchange(3'd2, -5000, 32'd70000, 32'd80000));
        // Intervals at the full 32-bit range and wrapping timestamps.
        send_request(exchange(3'd3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(exchange(3'd4, 20000, 32'hFFFF_0000, 32'd1));
        send_request(noise());
        send_request(noise());

        // A zero scale, then the largest scale with long flights to saturate.
        write_scale(16'd0);
        send_request(exchange(3'd5, 1000, 32'd40000, 32'd40000));
        write_scale(16'hFFFF);
        for (int k = 0; k < 3; k++) send_request(exchange(3'd6, 1 << 22, 32'd10, 32'd10));
        send_request(exchange(3'd6, -(1 << 22), 32'd10, 32'd10));
        random_phase(400);

        write_scale(16'($urandom));
        random_phase(200);
        // Hold the sender until every result is back, then resume.
        drain();
        random_phase(200);

        write_scale(16'd0);
        random_phase(200);
        write_scale(dstwr_pkg::CM_PER_TICK_RESET);
        calm = 1'b1;
        random_phase(250);
        calm = 1'b0;
        random_phase(380);

        drain();
        $display("covered %0d requests over several scale settings, %0d with zero denominator",
                 sent, ranges.zero_den_seen);
        $display("%0d results compared, %0d mismatches", ranges.matched, ranges.errors);
        if (ranges.errors == 0 && ranges.pending.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
